/* src/wdma_pkg.sv */
`default_nettype none
package wdma_pkg;

  localparam int WordBits = 32;

  typedef enum logic [2:0] {
    KIND_LOAD_A = 3'd0,
    KIND_LOAD_B = 3'd1,
    KIND_ADD    = 3'd2,
    KIND_SUB    = 3'd3,
    KIND_MUL    = 3'd4,
    KIND_DIV    = 3'd5
  } kind_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_POS  = 2'd1;
  localparam logic [1:0] ERR_NEG  = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  word_index;
    logic [31:0] word_value;
    logic        operand_sign;
    logic [7:0]  operand_scale;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_index;
    logic [31:0] out_word;
    logic        out_sign;
    logic [7:0]  out_scale;
    logic        is_remainder;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

endpackage
`default_nettype wire

/* src/wide_decimal_mantissa_alu.sv */
`default_nettype none
// wide_decimal_mantissa_alu
// in channel (in_valid/in_ready, payload in_item): one transaction per item.
// load items (kind 0/1) write one 32-bit mantissa word of A or B plus that
// operand's sign and scale; they give no result.
// add/sub run one wide add and one fix-up step (states S_PREP, S_ADD, S_FIX)
// before the first answer word is offered.
// multiply runs one shift-add step per mantissa bit and divide one
// shift-compare-subtract step per bit, in state S_ITER after S_PREP; on
// multiply overflow or a zero divisor S_PREP goes straight to S_EMIT.
// all of these steps share one wide adder in the datapath.
// results leave on out channel (out_valid/out_ready, payload out_item), one
// transaction per 32-bit word, least significant first, last on the final
// word; divide sends quotient words then remainder words.
// in_ready is low while an operation runs or its words are sent; a stalled
// receiver simply holds the current word and the sequencer waits.
// reset (rst, synchronous) clears both operands to zero with sign and scale 0.
module wide_decimal_mantissa_alu
  import wdma_pkg::*;
#(
  parameter int MANTISSA_BITS = 224
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);
  localparam int NWords  = (MANTISSA_BITS + WordBits - 1) / WordBits;
  localparam int TopBits = MANTISSA_BITS - (NWords - 1) * WordBits;
  localparam int CntW    = $clog2(MANTISSA_BITS + 1);
  localparam int WIdxW   = $clog2(NWords + 1);
  localparam int MB      = MANTISSA_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_ADD  = 6'b000100,
    S_FIX  = 6'b001000,
    S_ITER = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state;
  logic [MB-1:0] ma, mb, acc, aux;
  logic sa, sb;
  logic [7:0] sca, scb;
  logic [2:0] op;
  logic [CntW-1:0] cnt;
  logic [WIdxW-1:0] widx;
  logic phase_rem;
  logic res_sign;
  logic [7:0] res_scale;
  logic [1:0] res_err;
  logic carry;

  // shared adder
  logic [MB-1:0] add_a, add_b, add_s;
  logic add_ci, add_co;
  assign {add_co, add_s} = {1'b0, add_a} + {1'b0, add_b} + {{MB{1'b0}}, add_ci};

  // zero flags of A and B, used by the multiply overflow test and sign logic
  logic a_zero, b_zero, mb_zero;
  assign a_zero = (ma == '0);
  assign b_zero = (mb == '0);

  // remainder shifted left with the next dividend bit
  logic [MB-1:0] rsh;
  logic rhi;
  assign {rhi, rsh} = {aux, ma[cnt[CntW-1:0] - CntW'(1)]};

  logic sa_eff, sb_eff;
  assign sa_eff = a_zero ? 1'b0 : sa;
  assign sb_eff = b_zero ? 1'b0 : (sb ^ (op == KIND_SUB));

  always_comb begin
    add_a = ma;
    add_b = mb;
    add_ci = 1'b0;
    unique case (state)
      S_ADD: begin
        // opposite signs: the negative (nonzero) operand enters as ~m + 1
        add_a = (sa_eff != sb_eff && sa_eff) ? ~ma : ma;
        add_b = (sa_eff != sb_eff && sb_eff) ? ~mb : mb;
        add_ci = (sa_eff != sb_eff);
      end
      S_FIX: begin
        add_a = ~acc; add_b = '0; add_ci = 1'b1;
      end
      S_ITER: begin
        if (op == KIND_MUL) begin
          add_a = {acc[MB-2:0], 1'b0}; add_b = ma; add_ci = 1'b0;
        end else begin
          add_a = rsh; add_b = ~mb; add_ci = 1'b1;
        end
      end
      default: begin
        add_a = ma; add_b = mb; add_ci = 1'b0;
      end
    endcase
  end

  // multiply overflow: msb(a)+msb(b) >= MB, each msb found by scanning its operand from bit 0 up
  logic ovf;
  logic [CntW:0] msb_a, msb_b;
  always_comb begin
    msb_a = '0;
    msb_b = '0;
    for (int i = 0; i < MB; i++) begin
      if (ma[i]) msb_a = (CntW+1)'(i);
      if (mb[i]) msb_b = (CntW+1)'(i);
    end
  end
  assign ovf = !a_zero && !b_zero && ({1'b0, msb_a} + {1'b0, msb_b} >= (CntW+2)'(MB));
  assign mb_zero = b_zero;

  assign in_ready = (state == S_IDLE);

  logic [MB-1:0] cur;
  assign cur = phase_rem ? aux : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ma <= '0; mb <= '0; sa <= 1'b0; sb <= 1'b0; sca <= '0; scb <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= in_item.kind;
            if ((in_item.kind == KIND_LOAD_A || in_item.kind == KIND_LOAD_B)
                && int'(in_item.word_index) < NWords) begin
              for (int w = 0; w < NWords; w++) begin
                if (int'(in_item.word_index) == w) begin
                  for (int b = 0; b < WordBits; b++) begin
                    if (w * WordBits + b < MB) begin
                      if (in_item.kind == KIND_LOAD_A)
                        ma[w * WordBits + b] <= in_item.word_value[b];
                      else
                        mb[w * WordBits + b] <= in_item.word_value[b];
                    end
                  end
                end
              end
              if (in_item.kind == KIND_LOAD_A) begin
                sa <= in_item.operand_sign; sca <= in_item.operand_scale;
              end else begin
                sb <= in_item.operand_sign; scb <= in_item.operand_scale;
              end
            end else if (in_item.kind == KIND_ADD || in_item.kind == KIND_SUB ||
                         in_item.kind == KIND_MUL || in_item.kind == KIND_DIV) begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          res_sign <= 1'b0; res_scale <= '0; res_err <= ERR_NONE;
          phase_rem <= 1'b0; widx <= '0;
          acc <= '0; aux <= '0;
          cnt <= CntW'(MB);
          if (op == KIND_ADD || op == KIND_SUB) begin
            state <= S_ADD;
          end else if (op == KIND_MUL) begin
            if (ovf) begin
              res_err <= (sa ^ sb) ? ERR_NEG : ERR_POS;
              state <= S_EMIT;
              out_valid <= 1'b1;
            end else begin
              state <= S_ITER;
            end
          end else begin
            if (mb_zero) begin
              aux <= ma;
              state <= S_EMIT;
              out_valid <= 1'b1;
            end else begin
              state <= S_ITER;
            end
          end
        end
        S_ADD: begin
          acc <= add_s;
          carry <= add_co;
          res_scale <= a_zero ? 8'd0 : sca;
          if (sa_eff == sb_eff) begin
            res_sign <= sa_eff;
            if (add_co) res_err <= sa_eff ? ERR_NEG : ERR_POS;
          end else begin
            res_sign <= !add_co;
          end
          state <= S_FIX;
        end
        S_FIX: begin
          if (res_err != ERR_NONE || (res_sign && acc == '0) ||
              (!res_sign && acc == '0)) begin
            acc <= '0; res_sign <= 1'b0; res_scale <= '0;
          end else if (sa_eff != sb_eff && res_sign) begin
            acc <= add_s;
          end
          state <= S_EMIT;
          out_valid <= 1'b1;
        end
        S_ITER: begin
          if (op == KIND_MUL) begin
            acc <= mb[cnt - CntW'(1)] ? add_s : {acc[MB-2:0], 1'b0};
          end else begin
            // restoring step: subtract when bit shifted out or rem >= divisor
            if (rhi || add_co) begin
              aux <= add_s;
              acc[cnt - CntW'(1)] <= 1'b1;
            end else begin
              aux <= rsh;
            end
          end
          cnt <= cnt - CntW'(1);
          if (cnt == CntW'(1)) begin
            state <= S_EMIT;
            out_valid <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (widx == WIdxW'(NWords - 1)) begin
              widx <= '0;
              if (op == KIND_DIV && !phase_rem) begin
                phase_rem <= 1'b1;
              end else begin
                out_valid <= 1'b0;
                state <= S_IDLE;
              end
            end else begin
              widx <= widx + WIdxW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [WordBits-1:0] word_sel;
  always_comb begin
    word_sel = '0;
    for (int b = 0; b < WordBits; b++) begin
      for (int w = 0; w < NWords; w++) begin
        if (widx == WIdxW'(w) && w * WordBits + b < MB) word_sel[b] = cur[w * WordBits + b];
      end
    end
  end

  always_comb begin
    out_item.out_index    = 3'(widx);
    out_item.out_word     = word_sel;
    out_item.out_sign     = (op == KIND_ADD || op == KIND_SUB) ? res_sign : 1'b0;
    out_item.out_scale    = (op == KIND_ADD || op == KIND_SUB) ? res_scale : 8'd0;
    out_item.is_remainder = phase_rem;
    out_item.error_code   = res_err;
    out_item.last         = (widx == WIdxW'(NWords - 1)) &&
                            (op != KIND_DIV || phase_rem);
  end

  logic unused_ok;
  assign unused_ok = ^{carry, scb, TopBits};

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input open while results pending");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_item.last) |=> !out_valid)
    else $error("words after last");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.error_code != ERR_NONE) |-> out_item.out_word == '0)
    else $error("overflow with nonzero word");
endmodule
`default_nettype wire
